>>> hw/rtl/mck_pkg.sv
// Shared types, constants and the Morse code lookup for the character keyer.
package mck_pkg;

  localparam int unsigned DitW = 10;
  localparam int unsigned DurW = 13;
  localparam int unsigned CharW = 8;
  localparam int unsigned MaxElems = 5;
  localparam int unsigned LenW = 3;
  localparam logic [DitW-1:0] DitReset = 10'd50;

  // Multiple of the dit time that the duration unit produces.
  typedef enum logic [1:0] {
    MUL_ONE,
    MUL_TWO,
    MUL_FIVE,
    MUL_SIX
  } mult_e;

  // One looked-up character: element count and dash mask, first element in bit 0.
  typedef struct packed {
    logic                is_space;
    logic [LenW-1:0]     len;
    logic [MaxElems-1:0] pat;
  } code_t;

  function automatic code_t morse_lookup(logic [CharW-1:0] ch);
    logic [CharW-1:0] c;
    code_t r;
    c = ch;
    if ((ch >= "a") && (ch <= "z")) begin
      c = ch - 8'd32;
    end
    r.is_space = 1'b0;
    r.len = 3'd0;
    r.pat = 5'b00000;
    case (c)
      "A": begin r.len = 3'd2; r.pat = 5'b00010; end
      "B": begin r.len = 3'd4; r.pat = 5'b00001; end
      "C": begin r.len = 3'd4; r.pat = 5'b00101; end
      "D": begin r.len = 3'd3; r.pat = 5'b00001; end
      "E": begin r.len = 3'd1; r.pat = 5'b00000; end
      "F": begin r.len = 3'd4; r.pat = 5'b00100; end
      "G": begin r.len = 3'd3; r.pat = 5'b00011; end
      "H": begin r.len = 3'd4; r.pat = 5'b00000; end
      "I": begin r.len = 3'd2; r.pat = 5'b00000; end
      "J": begin r.len = 3'd4; r.pat = 5'b01110; end
      "K": begin r.len = 3'd3; r.pat = 5'b00101; end
      "L": begin r.len = 3'd4; r.pat = 5'b00010; end
      "M": begin r.len = 3'd2; r.pat = 5'b00011; end
      "N": begin r.len = 3'd2; r.pat = 5'b00001; end
      "O": begin r.len = 3'd3; r.pat = 5'b00111; end
      "P": begin r.len = 3'd4; r.pat = 5'b00110; end
      "Q": begin r.len = 3'd4; r.pat = 5'b01011; end
      "R": begin r.len = 3'd3; r.pat = 5'b00010; end
      "S": begin r.len = 3'd3; r.pat = 5'b00000; end
      "T": begin r.len = 3'd1; r.pat = 5'b00001; end
      "U": begin r.len = 3'd3; r.pat = 5'b00100; end
      "V": begin r.len = 3'd4; r.pat = 5'b01000; end
      "W": begin r.len = 3'd3; r.pat = 5'b00110; end
      "X": begin r.len = 3'd4; r.pat = 5'b01001; end
      "Y": begin r.len = 3'd4; r.pat = 5'b01101; end
      "Z": begin r.len = 3'd4; r.pat = 5'b00011; end
      "0": begin r.len = 3'd5; r.pat = 5'b11111; end
      "1": begin r.len = 3'd5; r.pat = 5'b11110; end
      "2": begin r.len = 3'd5; r.pat = 5'b11100; end
      "3": begin r.len = 3'd5; r.pat = 5'b11000; end
      "4": begin r.len = 3'd5; r.pat = 5'b10000; end
      "5": begin r.len = 3'd5; r.pat = 5'b00000; end
      "6": begin r.len = 3'd5; r.pat = 5'b00001; end
      "7": begin r.len = 3'd5; r.pat = 5'b00011; end
      "8": begin r.len = 3'd5; r.pat = 5'b00111; end
      "9": begin r.len = 3'd5; r.pat = 5'b01111; end
      " ": begin r.is_space = 1'b1; end
      default: begin r.len = 3'd0; end
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/mck_dur_unit.sv
// Shared shift-and-add unit that scales the dit time by a small constant.
module mck_dur_unit (
  input  logic [mck_pkg::DitW-1:0] dit_i,
  input  mck_pkg::mult_e           mult_i,
  output logic [mck_pkg::DurW-1:0] dur_o
);

  logic [mck_pkg::DurW-1:0] d1;
  logic [mck_pkg::DurW-1:0] d2;
  logic [mck_pkg::DurW-1:0] d4;
  logic [mck_pkg::DurW-1:0] add_a;
  logic [mck_pkg::DurW-1:0] add_b;

  assign d1 = {{(mck_pkg::DurW-mck_pkg::DitW){1'b0}}, dit_i};
  assign d2 = d1 << 1;
  assign d4 = d1 << 2;

  // One adder serves every multiple: 1 = d+0, 2 = 2d+0, 5 = 4d+d, 6 = 4d+2d.
  always_comb begin
    case (mult_i)
      mck_pkg::MUL_ONE: begin
        add_a = d1;
        add_b = '0;
      end
      mck_pkg::MUL_TWO: begin
        add_a = d2;
        add_b = '0;
      end
      mck_pkg::MUL_FIVE: begin
        add_a = d4;
        add_b = d1;
      end
      mck_pkg::MUL_SIX: begin
        add_a = d4;
        add_b = d2;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign dur_o = add_a + add_b;

endmodule

>>> hw/rtl/mck_seq.sv
// Segment sequencer: walks the elements of one character and registers each segment.
module mck_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [mck_pkg::CharW-1:0] ascii_char_i,
  output logic                      busy,
  output mck_pkg::mult_e            mult_o,
  input  logic [mck_pkg::DurW-1:0]  dur_i,
  output logic                      strobe_o,
  output logic                      key_on_o,
  output logic [mck_pkg::DurW-1:0]  duration_ms_o,
  output logic                      last_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ON    = 3'd1;
  localparam logic [2:0] S_GAP   = 3'd2;
  localparam logic [2:0] S_SPACE = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state_q, state_d;
  logic [mck_pkg::MaxElems-1:0] pat_q, pat_d;
  logic [mck_pkg::LenW-1:0] left_q, left_d;
  logic strobe_q, strobe_d;
  logic key_q, key_d;
  logic last_q, last_d;
  logic [mck_pkg::DurW-1:0] dur_q;
  logic accept;
  mck_pkg::code_t code;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign code   = mck_pkg::morse_lookup(ascii_char_i);

  always_comb begin
    state_d  = state_q;
    pat_d    = pat_q;
    left_d   = left_q;
    strobe_d = 1'b0;
    key_d    = 1'b0;
    last_d   = 1'b0;
    mult_o   = mck_pkg::MUL_ONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pat_d  = code.pat;
          left_d = code.len;
          if (code.len != '0) begin
            state_d = S_ON;
          end else if (code.is_space) begin
            state_d = S_SPACE;
          end else begin
            state_d = S_FINAL;
          end
        end
      end
      S_ON: begin
        strobe_d = 1'b1;
        key_d    = 1'b1;
        mult_o   = pat_q[0] ? mck_pkg::MUL_SIX : mck_pkg::MUL_TWO;
        state_d  = S_GAP;
      end
      S_GAP: begin
        strobe_d = 1'b1;
        mult_o   = mck_pkg::MUL_ONE;
        pat_d    = pat_q >> 1;
        left_d   = left_q - 1'b1;
        state_d  = (left_q == 3'd1) ? S_FINAL : S_ON;
      end
      S_SPACE: begin
        strobe_d = 1'b1;
        mult_o   = mck_pkg::MUL_FIVE;
        state_d  = S_FINAL;
      end
      S_FINAL: begin
        strobe_d = 1'b1;
        last_d   = 1'b1;
        mult_o   = mck_pkg::MUL_FIVE;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      left_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      left_q   <= left_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q  <= pat_d;
    key_q  <= key_d;
    last_q <= last_d;
    dur_q  <= dur_i;
  end

  assign strobe_o      = strobe_q;
  assign key_on_o      = key_q;
  assign duration_ms_o = dur_q;
  assign last_o        = last_q;

`ifndef ASSERT_OFF
  a_final_gives_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) |=> (strobe_o && last_o))
    else $error("final state did not emit the closing gap");

  a_mid_segment_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy)
    else $error("sequencer went idle before the closing gap");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !strobe_o))
    else $error("accepted request did not start a clean run");

  a_key_only_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && key_on_o) |-> !last_o)
    else $error("keyed segment marked as last");
`endif

endmodule

>>> hw/rtl/morse_char_keyer_top.sv
// Top level of the Morse character keyer: dit time register, sequencer and duration unit.
// An accepted request moves the sequencer out of idle; each segment is then registered with its strobe.
// Throughput: one segment per cycle; a character gives 2*elements+1 segments (space 2,
// unknown 1), busy stays high while the sequencer steps through them, and the sequencer
// takes no new request until busy is low again, once the closing gap has been registered.
// Reset (rst_ni low, asynchronous) idles the sequencer and sets the dit time to 50 ms.
// Segments are strobed for one cycle each; the receiver has no way to stall them.
module morse_char_keyer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [mck_pkg::CharW-1:0] ascii_char_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mck_pkg::DitW-1:0]  cfg_data_i,
  output logic                      strobe_o,
  output logic                      key_on_o,
  output logic [mck_pkg::DurW-1:0]  duration_ms_o,
  output logic                      last_o
);

  // The dit time is held here and fed to the duration unit every cycle.
  logic [mck_pkg::DitW-1:0] dit_q;
  mck_pkg::mult_e           mult;
  logic [mck_pkg::DurW-1:0] dur;

  // Configuration requests are taken whenever no character is in flight or being
  // requested, so a new dit time never lands on the same edge as a character.
  assign cfg_ready_o = !busy && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q <= mck_pkg::DitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dit_q <= cfg_data_i;
    end
  end

  // The sequencer picks the multiple of the dit time for the segment it is about
  // to register; the shared unit turns that into a duration in milliseconds.
  mck_dur_unit u_dur (
    .dit_i  (dit_q),
    .mult_i (mult),
    .dur_o  (dur)
  );

  mck_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .ascii_char_i  (ascii_char_i),
    .busy          (busy),
    .mult_o        (mult),
    .dur_i         (dur),
    .strobe_o      (strobe_o),
    .key_on_o      (key_on_o),
    .duration_ms_o (duration_ms_o),
    .last_o        (last_o)
  );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Morse character keyer: directed table, then random phases.
module tb;

  typedef logic [mck_pkg::CharW-1:0] char_t;
  typedef logic [mck_pkg::DitW-1:0]  dit_t;
  typedef logic [mck_pkg::DurW-1:0]  dur_t;

  // One keying segment as the block strobes it out.
  typedef struct packed {
    logic key_on;
    dur_t dur;
    logic last;
  } seg_t;

  // A row of the directed table. When n_typed is nonzero the expected segments are
  // written out by hand in s0..s2; otherwise the predictor supplies them.
  typedef struct packed {
    char_t      ch;
    logic [1:0] n_typed;
    seg_t       s0;
    seg_t       s1;
    seg_t       s2;
  } dir_row_t;

  localparam int unsigned NumRows = 22;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 55;
  localparam int unsigned MaxGap = 17;
  localparam int unsigned DrainLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  char_t               ascii_char_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  dit_t                cfg_data_i = '0;
  logic                strobe_o;
  logic                key_on_o;
  dur_t                duration_ms_o;
  logic                last_o;

  // Dot and dash patterns, written left to right in sending order.
  string letter_code [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_code [10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  // Segments that the block still owes us, oldest first.
  seg_t            pending_segs [$];
  dit_t            dit_now = mck_pkg::DitReset;
  logic            burst = 1'b0;
  int unsigned     n_errors = 0;
  int unsigned     n_items = 0;
  int unsigned     n_results = 0;
  int unsigned     n_settings = 1;

  // Directed requests, sent with the dit time at its reset value of 50 ms. Single
  // elements, space and some unknown codes are easy to work out by hand, so they carry
  // their expected segments; the rest go through the predictor.
  dir_row_t directed_rows [NumRows] = '{
    '{ch: "E", n_typed: 2'd3, s0: '{1'b1, 13'd100, 1'b0}, s1: '{1'b0, 13'd50, 1'b0},
      s2: '{1'b0, 13'd250, 1'b1}},
    '{ch: "T", n_typed: 2'd3, s0: '{1'b1, 13'd300, 1'b0}, s1: '{1'b0, 13'd50, 1'b0},
      s2: '{1'b0, 13'd250, 1'b1}},
    '{ch: "e", n_typed: 2'd3, s0: '{1'b1, 13'd100, 1'b0}, s1: '{1'b0, 13'd50, 1'b0},
      s2: '{1'b0, 13'd250, 1'b1}},
    '{ch: " ", n_typed: 2'd2, s0: '{1'b0, 13'd250, 1'b0}, s1: '{1'b0, 13'd250, 1'b1},
      s2: '0},
    '{ch: 8'h00, n_typed: 2'd1, s0: '{1'b0, 13'd250, 1'b1}, s1: '0, s2: '0},
    '{ch: 8'h80, n_typed: 2'd1, s0: '{1'b0, 13'd250, 1'b1}, s1: '0, s2: '0},
    '{ch: 8'hFF, n_typed: 2'd1, s0: '{1'b0, 13'd250, 1'b1}, s1: '0, s2: '0},
    '{ch: "A", default: '0},
    '{ch: "Z", default: '0},
    '{ch: "a", default: '0},
    '{ch: "z", default: '0},
    '{ch: "0", default: '0},
    '{ch: "9", default: '0},
    '{ch: "5", default: '0},
    '{ch: "Q", default: '0},
    '{ch: "Y", default: '0},
    '{ch: "@", default: '0},
    '{ch: "[", default: '0},
    '{ch: 8'h60, default: '0},
    '{ch: "{", default: '0},
    '{ch: "/", default: '0},
    '{ch: ":", default: '0}
  };

  morse_char_keyer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .ascii_char_i  (ascii_char_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .strobe_o      (strobe_o),
    .key_on_o      (key_on_o),
    .duration_ms_o (duration_ms_o),
    .last_o        (last_o)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // A segment of mult dit times.
  function automatic seg_t span(input logic key, input int unsigned mult,
                                input dit_t dit, input logic fin);
    seg_t s;
    s.key_on = key;
    s.dur = dur_t'(mult * dit);
    s.last = fin;
    return s;
  endfunction

  // Queues the segments that one character should produce at the given dit time.
  // Lower case folds to upper case; anything that is not a letter, digit or space
  // sends nothing but the closing word gap.
  function automatic void morse_segments(input char_t ch, input dit_t dit);
    char_t up;
    string code;
    up = ch;
    code = "";
    if ((ch >= "a") && (ch <= "z")) begin
      up = ch - 8'd32;
    end
    if ((up >= "A") && (up <= "Z")) begin
      code = letter_code[up - "A"];
    end else if ((up >= "0") && (up <= "9")) begin
      code = digit_code[up - "0"];
    end else if (up == " ") begin
      pending_segs.push_back(span(1'b0, 5, dit, 1'b0));
    end
    for (int i = 0; i < code.len(); i++) begin
      pending_segs.push_back(span(1'b1, (code[i] == "-") ? 6 : 2, dit, 1'b0));
      pending_segs.push_back(span(1'b0, 1, dit, 1'b0));
    end
    pending_segs.push_back(span(1'b0, 5, dit, 1'b1));
  endfunction

  // Random character: mostly valid Morse symbols of both cases, some arbitrary bytes.
  function automatic char_t pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return char_t'("A" + $urandom_range(0, 25));
      4, 5:       return char_t'("a" + $urandom_range(0, 25));
      6, 7:       return char_t'("0" + $urandom_range(0, 9));
      8:          return " ";
      default:    return char_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Presents one request and returns at the rising edge where it is taken
  // (start high, busy low). The idle gap is counted from the previous request,
  // so it lands anywhere in the block's busy window. With no gap, start simply
  // stays high and only the character changes.
  task automatic send_char(input char_t ch);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    ascii_char_i <= ch;
    do @(posedge clk_i); while (busy !== 1'b0);
    n_items++;
  endtask

  // Stops sending and waits for every owed segment, then lets the block settle.
  // Segments that never arrive are reported and dropped.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while ((pending_segs.size() != 0) && (waited < DrainLimit)) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_segs.size() != 0) begin
      $display("%0t: %0d expected segments never arrived", $time, pending_segs.size());
      n_errors++;
      pending_segs.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the dit time once the block is idle.
  task automatic set_dit(input dit_t val);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    dit_now = val;
    n_settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Every strobed segment is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_segments
    seg_t want;
    if (rst_ni && (strobe_o === 1'b1)) begin
      n_results++;
      if (pending_segs.size() == 0) begin
        $display("%0t: unexpected segment key_on=%0b duration_ms=%0d last=%0b",
                 $time, key_on_o, duration_ms_o, last_o);
        n_errors++;
      end else begin
        want = pending_segs.pop_front();
        if (key_on_o !== want.key_on) begin
          $display("%0t: key_on expected %0b, got %0b", $time, want.key_on, key_on_o);
          n_errors++;
        end
        if (duration_ms_o !== want.dur) begin
          $display("%0t: duration_ms expected %0d, got %0d", $time, want.dur,
                   duration_ms_o);
          n_errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b, got %0b", $time, want.last, last_o);
          n_errors++;
        end
      end
    end
  end

  initial begin : stimulus
    char_t ch;
    dit_t  dit;
    // Reset is held low from time zero and released on a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at the reset dit time.
    foreach (directed_rows[r]) begin
      send_char(directed_rows[r].ch);
      if (directed_rows[r].n_typed == 2'd0) begin
        morse_segments(directed_rows[r].ch, dit_now);
      end else begin
        pending_segs.push_back(directed_rows[r].s0);
        if (directed_rows[r].n_typed >= 2'd2) begin
          pending_segs.push_back(directed_rows[r].s1);
        end
        if (directed_rows[r].n_typed == 2'd3) begin
          pending_segs.push_back(directed_rows[r].s2);
        end
      end
    end

    // Random phases. Each one starts with the sender held off until all owed
    // segments are in, then a new dit time: zero, the register maximum, the
    // smallest and largest nominal values, then random settings.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       dit = '0;
        1:       dit = '1;
        2:       dit = dit_t'(1);
        3:       dit = dit_t'(1000);
        default: dit = dit_t'($urandom_range(0, 1023));
      endcase
      set_dit(dit);
      // Some phases run back to back with no idle cycles at all.
      burst = ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) begin
        ch = pick_char();
        send_char(ch);
        morse_segments(ch, dit_now);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d characters under %0d dit time settings, including zero and 1023.",
             n_items, n_settings);
    $display("Checked %0d keying segments against the predicted sequence.", n_results);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #300000;
    $display("Timeout: the run did not complete.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
